FILE: design/irpd_pkg.sv
// shared types, register codes and the checksum fold of the ir frame receiver
`timescale 1ns / 1ps
package irpd_pkg;

  localparam int unsigned GapWidth   = 16;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CountWidth = 6;

  typedef enum logic [2:0] {
    REG_START_GAP_MIN = 3'd0,
    REG_START_GAP_MAX = 3'd1,
    REG_ONE_GAP_MIN   = 3'd2,
    REG_ONE_GAP_MAX   = 3'd3,
    REG_ZERO_GAP_MIN  = 3'd4,
    REG_ZERO_GAP_MAX  = 3'd5
  } irpd_reg_t;

  localparam logic [GapWidth-1:0] StartGapMinReset = 16'd10800;
  localparam logic [GapWidth-1:0] StartGapMaxReset = 16'd16875;
  localparam logic [GapWidth-1:0] OneGapMinReset   = 16'd1800;
  localparam logic [GapWidth-1:0] OneGapMaxReset   = 16'd2812;
  localparam logic [GapWidth-1:0] ZeroGapMinReset  = 16'd896;
  localparam logic [GapWidth-1:0] ZeroGapMaxReset  = 16'd1400;

  typedef enum logic {
    ACT_LEVEL = 1'b0,
    ACT_READ  = 1'b1
  } irpd_action_t;

  typedef struct packed {
    logic [GapWidth-1:0] start_gap_min;
    logic [GapWidth-1:0] start_gap_max;
    logic [GapWidth-1:0] one_gap_min;
    logic [GapWidth-1:0] one_gap_max;
    logic [GapWidth-1:0] zero_gap_min;
    logic [GapWidth-1:0] zero_gap_max;
  } irpd_cfg_t;

  typedef struct packed {
    irpd_action_t         action;
    logic                 line_level;
    logic [TimeWidth-1:0] time_us;
  } irpd_item_t;

  typedef struct packed {
    logic                 frame_ready;
    logic                 frame_valid;
    logic [WordWidth-1:0] frame_word;
  } irpd_result_t;

  localparam logic [WordWidth-1:0] MaskShl2 = 32'h0203_FDFC;
  localparam logic [WordWidth-1:0] MaskShl1 = 32'h01FE_01FE;
  localparam logic [WordWidth-1:0] MaskShr0 = 32'h0003_FFFF;
  localparam logic [WordWidth-1:0] MaskShr1 = 32'h0002_0000;
  localparam logic [WordWidth-1:0] MaskShr2 = 32'h0001_FC00;
  localparam logic [WordWidth-1:0] MaskShr3 = 32'h0003_FE00;
  localparam logic [WordWidth-1:0] MaskShr4 = 32'h000E_03FC;
  localparam logic [WordWidth-1:0] MaskShr5 = 32'h0003_FE02;
  localparam logic [WordWidth-1:0] CheckMask = 32'h3FC0_0000;

  function automatic logic [WordWidth-1:0] fold_checksum(input logic [WordWidth-1:0] w);
    logic [WordWidth-1:0] c;
    logic [7:0]           sum;
    c = ((w << 2) & MaskShl2) ^ ((w << 1) & MaskShl1) ^ (w & MaskShr0) ^
        ((w >> 1) & MaskShr1) ^ ((w >> 2) & MaskShr2) ^ ((w >> 3) & MaskShr3) ^
        ((w >> 4) & MaskShr4) ^ ((w >> 5) & MaskShr5);
    sum = c[7:0] ^ c[15:8] ^ c[23:16] ^ c[31:24];
    return w ^ {sum, 24'h0};
  endfunction

endpackage

FILE: design/irpd_cfg_regs.sv
// timing window registers with their write port
`timescale 1ns / 1ps
module irpd_cfg_regs
  import irpd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [2:0]          wr_index,
  input  logic [GapWidth-1:0] wr_data,
  output irpd_cfg_t           cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_gap_min <= StartGapMinReset;
      cfg.start_gap_max <= StartGapMaxReset;
      cfg.one_gap_min   <= OneGapMinReset;
      cfg.one_gap_max   <= OneGapMaxReset;
      cfg.zero_gap_min  <= ZeroGapMinReset;
      cfg.zero_gap_max  <= ZeroGapMaxReset;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_START_GAP_MIN: cfg.start_gap_min <= wr_data;
        REG_START_GAP_MAX: cfg.start_gap_max <= wr_data;
        REG_ONE_GAP_MIN:   cfg.one_gap_min   <= wr_data;
        REG_ONE_GAP_MAX:   cfg.one_gap_max   <= wr_data;
        REG_ZERO_GAP_MIN:  cfg.zero_gap_min  <= wr_data;
        REG_ZERO_GAP_MAX:  cfg.zero_gap_max  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/irpd_frame_engine.sv
// frame state and per-request decode: gap classification, bit shifting, read fold
`timescale 1ns / 1ps
module irpd_frame_engine
  import irpd_pkg::*;
#(
  parameter int unsigned BITS_PER_FRAME = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  irpd_item_t   item,
  input  irpd_cfg_t    cfg,
  output irpd_result_t result
);

  localparam logic [CountWidth-1:0] HoldCount = CountWidth'(BITS_PER_FRAME + 1);

  logic                  last_level;
  logic [TimeWidth-1:0]  last_edge_time;
  logic [WordWidth-1:0]  shift_word;
  logic [CountWidth-1:0] bit_count;
  logic                  frame_held;

  logic                  last_level_next;
  logic [TimeWidth-1:0]  last_edge_time_next;
  logic [WordWidth-1:0]  shift_word_next;
  logic [CountWidth-1:0] bit_count_next;
  logic                  frame_held_next;

  logic [TimeWidth-1:0]  gap;
  logic                  is_start;
  logic                  is_one;
  logic                  is_zero;
  logic [WordWidth-1:0]  folded;
  logic [CountWidth-1:0] count_inc;

  function automatic logic in_window(input logic [TimeWidth-1:0] v,
                                     input logic [GapWidth-1:0]  lo,
                                     input logic [GapWidth-1:0]  hi);
    return (v > TimeWidth'(lo)) && (v < TimeWidth'(hi));
  endfunction

  assign gap       = item.time_us - last_edge_time;
  assign is_start  = in_window(gap, cfg.start_gap_min, cfg.start_gap_max);
  assign is_one    = in_window(gap, cfg.one_gap_min, cfg.one_gap_max);
  assign is_zero   = in_window(gap, cfg.zero_gap_min, cfg.zero_gap_max);
  assign folded    = fold_checksum(shift_word);
  assign count_inc = bit_count + CountWidth'(1);

  always_comb begin
    last_level_next     = last_level;
    last_edge_time_next = last_edge_time;
    shift_word_next     = shift_word;
    bit_count_next      = bit_count;
    frame_held_next     = frame_held;
    result.frame_ready  = frame_held;
    result.frame_valid  = 1'b0;
    result.frame_word   = '0;
    if (item.action == ACT_READ) begin
      if (frame_held) begin
        shift_word_next = '0;
        bit_count_next  = '0;
        frame_held_next = 1'b0;
        if ((folded & CheckMask) == '0) begin
          result.frame_valid = 1'b1;
          result.frame_word  = folded;
        end
      end
    end else if (!frame_held && (item.line_level != last_level)) begin
      last_level_next = item.line_level;
      if (!item.line_level) begin
        last_edge_time_next = item.time_us;
        priority if (is_start) begin
          bit_count_next  = CountWidth'(1);
          shift_word_next = '0;
        end else if ((bit_count != '0) && (is_one || is_zero)) begin
          shift_word_next = {is_one, shift_word[WordWidth-1:1]};
          bit_count_next  = count_inc;
          frame_held_next = (count_inc == HoldCount);
        end else begin
          // gap outside the start and bit windows, or no frame started: frame state is kept
          bit_count_next = bit_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b0;
      last_edge_time <= '0;
      shift_word     <= '0;
      bit_count      <= '0;
      frame_held     <= 1'b0;
    end else if (take) begin
      last_level     <= last_level_next;
      last_edge_time <= last_edge_time_next;
      shift_word     <= shift_word_next;
      bit_count      <= bit_count_next;
      frame_held     <= frame_held_next;
    end
  end

endmodule

FILE: design/ir_pulse_distance_frame_receiver_core.sv
// top level of the ir pulse distance frame receiver
`timescale 1ns / 1ps
// Decodes an inverted infrared line by pulse distance from timestamped level
// change requests and hands out the held 32-bit frame on a read request. Every
// request gives exactly one result. A request is taken into an input register
// and decoded into an output register once that is free, so one request can
// be accepted in every cycle while the output does not stall; the only loop is
// the frame state update inside the decode stage. The user must write timing
// windows through the cfg port only while no request is in flight; not enforced.
module ir_pulse_distance_frame_receiver_core
  import irpd_pkg::*;
#(
  parameter int unsigned BITS_PER_FRAME = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // line_level, time_us, zero fill
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // frame_word
  output logic [1:0]  m_axis_tuser,  // frame_ready, frame_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  irpd_cfg_t    cfg;
  irpd_item_t   in_item;
  logic         in_valid;
  irpd_result_t result;
  irpd_result_t out_result;
  logic         out_valid;
  logic         advance;
  logic         s_accept;

  assign cfg_ready = 1'b1;

  irpd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_item.action     <= irpd_action_t'(s_axis_tuser);
      in_item.line_level <= s_axis_tdata[0];
      in_item.time_us    <= s_axis_tdata[32:1];
    end
  end

  irpd_frame_engine #(
    .BITS_PER_FRAME (BITS_PER_FRAME)
  ) u_frame_engine (
    .clk    (clk),
    .rst    (rst),
    .take   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result.frame_word;
  assign m_axis_tuser  = {out_result.frame_valid, out_result.frame_ready};

endmodule

FILE: tb/ir_pulse_distance_frame_receiver_core_tb.sv
// self-checking testbench for the ir pulse distance frame receiver core
`timescale 1ns / 1ps
module ir_pulse_distance_frame_receiver_core_tb;
  import irpd_pkg::*;

  localparam int FrameBits  = 32;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  class frame_scoreboard;
    irpd_cfg_t    windows;
    logic         line_q;
    logic [31:0]  edge_t;
    logic [31:0]  shreg;
    logic [5:0]   nbits;
    logic         held;
    irpd_result_t expected_results[$];
    int           mismatches;

    function new();
      windows.start_gap_min = 16'd10800;
      windows.start_gap_max = 16'd16875;
      windows.one_gap_min   = 16'd1800;
      windows.one_gap_max   = 16'd2812;
      windows.zero_gap_min  = 16'd896;
      windows.zero_gap_max  = 16'd1400;
      line_q     = 1'b0;
      edge_t     = '0;
      shreg      = '0;
      nbits      = '0;
      held       = 1'b0;
      mismatches = 0;
    endfunction

    static function logic [31:0] fold_word(input logic [31:0] w);
      logic [31:0] c;
      logic [7:0]  s;
      c = ((w << 2) & 32'h0203_FDFC) ^ ((w << 1) & 32'h01FE_01FE) ^
          (w & 32'h0003_FFFF) ^ ((w >> 1) & 32'h0002_0000) ^
          ((w >> 2) & 32'h0001_FC00) ^ ((w >> 3) & 32'h0003_FE00) ^
          ((w >> 4) & 32'h000E_03FC) ^ ((w >> 5) & 32'h0003_FE02);
      s = c[31:24] ^ c[23:16] ^ c[15:8] ^ c[7:0];
      return {w[31:24] ^ s, w[23:0]};
    endfunction

    function bit between(input logic [31:0] v, input logic [15:0] lo, input logic [15:0] hi);
      return (v > {16'd0, lo}) && (v < {16'd0, hi});
    endfunction

    function void shift_in(input logic b);
      shreg = {b, shreg[31:1]};
      nbits = nbits + 6'd1;
      if (nbits == 6'(FrameBits + 1)) held = 1'b1;
    endfunction

    function void write_reg(input irpd_reg_t idx, input logic [15:0] v);
      case (idx)
        REG_START_GAP_MIN: windows.start_gap_min = v;
        REG_START_GAP_MAX: windows.start_gap_max = v;
        REG_ONE_GAP_MIN:   windows.one_gap_min   = v;
        REG_ONE_GAP_MAX:   windows.one_gap_max   = v;
        REG_ZERO_GAP_MIN:  windows.zero_gap_min  = v;
        REG_ZERO_GAP_MAX:  windows.zero_gap_max  = v;
        default: ;
      endcase
    endfunction

    function void note_request(input irpd_item_t it);
      irpd_result_t r;
      logic [31:0]  gap;
      logic [31:0]  folded;
      r.frame_ready = held;
      r.frame_valid = 1'b0;
      r.frame_word  = '0;
      if (it.action == ACT_READ) begin
        if (held) begin
          folded = fold_word(shreg);
          shreg  = '0;
          nbits  = '0;
          held   = 1'b0;
          if ((folded & 32'h3FC0_0000) == 32'd0) begin
            r.frame_valid = 1'b1;
            r.frame_word  = folded;
          end
        end
      end else if (!held && it.line_level != line_q) begin
        line_q = it.line_level;
        if (!it.line_level) begin
          gap    = it.time_us - edge_t;
          edge_t = it.time_us;
          if (between(gap, windows.start_gap_min, windows.start_gap_max)) begin
            nbits = 6'd1;
            shreg = '0;
          end else if (nbits != 6'd0) begin
            if (between(gap, windows.one_gap_min, windows.one_gap_max)) shift_in(1'b1);
            else if (between(gap, windows.zero_gap_min, windows.zero_gap_max)) shift_in(1'b0);
          end
        end
      end
      expected_results.push_back(r);
    endfunction

    function void flag(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %h got %h", $realtime, what, exp_v, act_v);
    endfunction

    function void check_result(input irpd_result_t got);
      irpd_result_t want;
      if (expected_results.size() == 0) begin
        flag("result with no request pending", 32'd0, got.frame_word);
        return;
      end
      want = expected_results.pop_front();
      if (got.frame_ready != want.frame_ready)
        flag("frame_ready", 32'(want.frame_ready), 32'(got.frame_ready));
      if (got.frame_valid != want.frame_valid)
        flag("frame_valid", 32'(want.frame_valid), 32'(got.frame_valid));
      if (got.frame_word != want.frame_word)
        flag("frame_word", want.frame_word, got.frame_word);
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;  // line_level, time_us, zero fill
  logic        s_axis_tuser  = 1'b0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // frame_word
  logic [1:0]  m_axis_tuser;  // frame_ready, frame_valid
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index     = '0;
  logic [15:0] cfg_data      = '0;

  frame_scoreboard sb;
  int        tx_idle_pct = 8;
  int        rx_idle_pct = 83;
  int        sent        = 0;
  int        cycles      = 0;
  logic      holding     = 1'b0;
  irpd_cfg_t win;
  event      hold_start;

  ir_pulse_distance_frame_receiver_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= !holding && ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // long receiver hold-off so the pipeline backs up into the input
  always begin
    @(hold_start);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(irpd_result_t'({m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata}));
  end

  task automatic send(input irpd_item_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, it.time_us, it.line_level};
    s_axis_tuser  <= it.action;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(it);
    sent++;
    if ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic level_event(input logic lvl, input logic [31:0] t);
    irpd_item_t it;
    it.action     = ACT_LEVEL;
    it.line_level = lvl;
    it.time_us    = t;
    send(it);
  endtask

  task automatic read_frame();
    irpd_item_t it;
    it.action     = ACT_READ;
    it.line_level = 1'($urandom);
    it.time_us    = $urandom;
    send(it);
  endtask

  // falling change one gap after the last falling change, with a rise first if needed
  task automatic fall_after(input logic [31:0] gap);
    if (sb.line_q == 1'b0) level_event(1'b1, $urandom);
    level_event(1'b0, sb.edge_t + gap);
  endtask

  function automatic logic [31:0] pick_gap(input logic [15:0] lo, input logic [15:0] hi);
    int l;
    int h;
    l = lo;
    h = hi;
    if (h - l >= 2) return $urandom_range(h - 1, l + 1);
    return $urandom_range(65535, 0);
  endfunction

  function automatic logic [31:0] pick_good_word();
    logic [31:0] w;
    for (int k = 0; k < 20000; k++) begin
      w = $urandom;
      if ((frame_scoreboard::fold_word(w) & 32'h3FC0_0000) == 32'd0) return w;
    end
    return 32'd0;
  endfunction

  task automatic noise_item();
    case ($urandom_range(4, 0))
      0: read_frame();
      1: level_event(sb.line_q, $urandom);
      2: level_event(1'($urandom), $urandom);
      3: fall_after($urandom_range(65535, 0));
      default: fall_after($urandom);
    endcase
  endtask

  task automatic send_frame(input logic [31:0] word, input int noise_pct);
    fall_after(pick_gap(sb.windows.start_gap_min, sb.windows.start_gap_max));
    for (int i = 0; i < FrameBits; i++) begin
      if ($urandom_range(99, 0) < noise_pct) noise_item();
      if (word[i]) fall_after(pick_gap(sb.windows.one_gap_min, sb.windows.one_gap_max));
      else fall_after(pick_gap(sb.windows.zero_gap_min, sb.windows.zero_gap_max));
    end
    // changes while the frame is held must be ignored
    repeat ($urandom_range(3, 1)) level_event(1'($urandom), $urandom);
    if ($urandom_range(99, 0) < 90) read_frame();
  endtask

  task automatic random_traffic(input int count);
    int target;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(99, 0) < 60) begin
        if ($urandom_range(1, 0) == 0) send_frame(pick_good_word(), $urandom_range(10, 0));
        else send_frame($urandom, $urandom_range(10, 0));
      end else begin
        repeat ($urandom_range(6, 1)) noise_item();
      end
    end
  endtask

  task automatic program_windows(input irpd_cfg_t c);
    irpd_reg_t   idx[6];
    logic [15:0] vals[6];
    idx  = '{REG_START_GAP_MIN, REG_START_GAP_MAX, REG_ONE_GAP_MIN,
             REG_ONE_GAP_MAX, REG_ZERO_GAP_MIN, REG_ZERO_GAP_MAX};
    vals = '{c.start_gap_min, c.start_gap_max, c.one_gap_min,
             c.one_gap_max, c.zero_gap_min, c.zero_gap_max};
    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    for (int k = 0; k < 6; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // edge cases on the reset windows
    begin
      irpd_item_t it;
      it.action     = ACT_READ;
      it.line_level = 1'b1;
      it.time_us    = 32'hFFFF_FFFF;
      send(it);
    end
    level_event(1'b0, 32'h0000_0000);
    level_event(1'b1, 32'hFFFF_FFFF);
    level_event(1'b0, 32'h0000_0000);
    level_event(1'b1, 32'h1234_5678);
    level_event(1'b1, 32'h8765_4321);
    level_event(1'b0, 32'hFFFF_F000);
    level_event(1'b1, 32'h0000_0000);
    level_event(1'b0, 32'hFFFF_F000 + 32'd12000);
    fall_after(32'd2000);
    fall_after(32'd1000);
    fall_after(32'd5000);
    fall_after(32'd1800);
    fall_after(32'd2812);
    fall_after(32'd896);
    fall_after(32'd1400);
    fall_after(32'd10800);
    fall_after(32'd16874);
    read_frame();
    send_frame(pick_good_word(), 0);
    read_frame();
    send_frame($urandom, 0);
    read_frame();
    random_traffic(40);

    win.start_gap_min = 16'($urandom_range(6000, 4000));
    win.start_gap_max = 16'($urandom_range(11000, 9000));
    win.one_gap_min   = 16'($urandom_range(3000, 2500));
    win.one_gap_max   = 16'($urandom_range(4500, 3500));
    win.zero_gap_min  = 16'($urandom_range(300, 100));
    win.zero_gap_max  = 16'($urandom_range(1200, 800));
    program_windows(win);
    random_traffic(60);

    // extremes with overlapping bit windows
    tx_idle_pct = 83;
    rx_idle_pct = 8;
    win.start_gap_min = 16'd60000;
    win.start_gap_max = 16'd65535;
    win.one_gap_min   = 16'd0;
    win.one_gap_max   = 16'd400;
    win.zero_gap_min  = 16'd0;
    win.zero_gap_max  = 16'd65535;
    program_windows(win);
    random_traffic(60);

    // empty one window, back to nominal start and zero windows
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    win.start_gap_min = 16'd10800;
    win.start_gap_max = 16'd16875;
    win.one_gap_min   = 16'd2000;
    win.one_gap_max   = 16'd2000;
    win.zero_gap_min  = 16'd896;
    win.zero_gap_max  = 16'd1400;
    program_windows(win);
    -> hold_start;
    send_frame(32'd0, 0);
    random_traffic(40);

    s_axis_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
